// File: rtl/raid0_stripe_request_splitter_assert.svh
// ----------------------------------------------------------------------------
// raid0_stripe_request_splitter_assert.svh
// Assertion macros for the stripe request splitter checker. The clock and
// reset are taken from the scope of the use: clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH
`define RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge outside reset
`define RSRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge outside reset
`define RSRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rsrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_pkg
// Shared widths, constants and types of the RAID0 stripe request splitter.
// ----------------------------------------------------------------------------
package rsrs_pkg;

	// Field widths
	localparam int OFF_W      = 48;
	localparam int LEN_W      = 16;
	localparam int KIB_W      = 21;
	localparam int WID_W      = 8;
	localparam int WITHIN_W   = 30;
	localparam int STRIPE_W   = 31;
	localparam int KIB_SHIFT  = 10;
	localparam int QUO_W      = OFF_W - KIB_SHIFT;
	localparam int REM_W      = WITHIN_W - KIB_SHIFT;
	localparam int DIV_CNT_W  = $clog2(QUO_W);

	// Limits and reset values
	localparam logic [LEN_W-1:0] MAX_REQ_LEN   = 16'd64512;
	localparam logic [KIB_W-1:0] MAX_KIB       = 21'd1048576;
	localparam logic [KIB_W-1:0] RST_KIB       = 21'd128;
	localparam logic [WID_W-1:0] RST_WIDTH     = 8'd1;
	localparam logic             RST_RAID0     = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = KIB_W;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_SIZE_KIB = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_IS_RAID0 = 2'd2;

	typedef struct packed {
		logic [OFF_W-1:0] request_offset;
		logic [LEN_W-1:0] request_length;
	} request_t;

	typedef struct packed {
		logic [OFF_W-1:0]    object_id;
		logic [WITHIN_W-1:0] object_byte;
		logic [LEN_W-1:0]    piece_length;
		logic [WID_W-1:0]    target_index;
		logic [LEN_W-1:0]    bytes_done;
		logic                unsupported;
		logic                last_piece;
	} result_t;

	// Normalized configuration seen by the datapath
	typedef struct packed {
		logic [KIB_W-1:0] stripe_kib;
		logic [WID_W-1:0] width;
		logic             raid0;
	} cfg_t;

	typedef enum logic {
		CMD_SPLIT,
		CMD_UNSUP
	} cmd_kind_t;

	// Classified request queued between front and back
	typedef struct packed {
		cmd_kind_t        kind;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [QUO_W-1:0] dividend;
		logic [KIB_W-1:0] divisor;
		logic [WID_W-1:0] modulus;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
		logic [REM_W-1:0] remainder;
		logic [WID_W-1:0] residue;
	} div_rsp_t;

	typedef enum logic [1:0] {
		WALK_IDLE,
		WALK_DIV,
		WALK_EMIT
	} walk_state_t;

endpackage

// File: rtl/rsrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_front
// Accepts requests, drops zero-length ones, clamps the length to the limit
// and to the top of the address space, and tags the policy.
// ----------------------------------------------------------------------------
module rsrs_front #(
	parameter int OFFSET_BITS = 48
) (
	input  logic              request_valid,
	output logic              request_stall,
	input  rsrs_pkg::request_t request,
	input  rsrs_pkg::cfg_t    cfg,
	input  logic              queue_full,
	output logic              push,
	output rsrs_pkg::cmd_t    cmd
);

	localparam int OW = rsrs_pkg::OFF_W;
	localparam int LW = rsrs_pkg::LEN_W;
	localparam logic [OW-1:0] OFF_MASK =
		(OFFSET_BITS >= OW) ? {OW{1'b1}} : ((OW'(1) << OFFSET_BITS) - OW'(1));
	localparam bit CUT_TOP = (OFFSET_BITS <= OW);

	logic [OW-1:0] off;
	logic [OW-1:0] avail;
	logic [LW-1:0] len_sat;
	logic [LW-1:0] len_m1;
	logic          cut;

	// Clamp length and cut at the last address
	always_comb begin
		off     = request.request_offset & OFF_MASK;
		avail   = OFF_MASK - off;
		len_sat = (request.request_length > rsrs_pkg::MAX_REQ_LEN) ?
			rsrs_pkg::MAX_REQ_LEN : request.request_length;
		len_m1  = len_sat - LW'(1);
		cut     = CUT_TOP && ({{(OW-LW){1'b0}}, len_m1} > avail);

		cmd.kind   = cfg.raid0 ? rsrs_pkg::CMD_SPLIT : rsrs_pkg::CMD_UNSUP;
		cmd.offset = off;
		cmd.length = cut ? (avail[LW-1:0] + LW'(1)) : len_sat;
	end

	// Hold off while the queue is full; zero-length requests vanish here
	assign request_stall = queue_full;
	assign push          = request_valid && !queue_full && (request.request_length != '0);

endmodule

// File: rtl/rsrs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rsrs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsrs_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output rsrs_pkg::cmd_t head
);

	rsrs_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/rsrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_div
// Bit-serial restoring divider: one quotient bit per cycle. The quotient
// bits, as they appear from the top, are also reduced modulo a second small
// divisor, so the target index comes out with the object number.
// ----------------------------------------------------------------------------
module rsrs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rsrs_pkg::div_req_t req,
	output rsrs_pkg::div_rsp_t rsp
);

	localparam int QW = rsrs_pkg::QUO_W;
	localparam int RW = rsrs_pkg::REM_W;
	localparam int KW = rsrs_pkg::KIB_W;
	localparam int WW = rsrs_pkg::WID_W;
	localparam int CW = rsrs_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] dvd_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [WW-1:0] res_q;
	logic [KW-1:0] dvs_q;
	logic [WW-1:0] modu_q;

	logic [KW-1:0] trial;
	logic          qbit;
	logic [RW-1:0] rem_d;
	logic [WW:0]   trial_m;
	logic [WW-1:0] res_d;

	// One restoring step, plus the running residue of the quotient
	always_comb begin
		trial   = {rem_q, dvd_q[QW-1]};
		qbit    = (trial >= dvs_q);
		rem_d   = qbit ? RW'(trial - dvs_q) : trial[RW-1:0];
		trial_m = {res_q, qbit};
		res_d   = (trial_m >= {1'b0, modu_q}) ? WW'(trial_m - {1'b0, modu_q}) :
			trial_m[WW-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			quo_q  <= '0;
			rem_q  <= '0;
			res_q  <= '0;
			dvs_q  <= req.divisor;
			modu_q <= req.modulus;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
			rem_q <= rem_d;
			res_q <= res_d;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
	assign rsp.residue   = res_q;

endmodule

// File: rtl/rsrs_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_walk
// Back end: takes a queued request, locates its first object through the
// divider, then walks it one piece per cycle into the result register while not stalled.
// ----------------------------------------------------------------------------
module rsrs_walk #(
	parameter int MAX_PIECES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rsrs_pkg::cfg_t     cfg,
	input  logic               cmd_valid,
	input  rsrs_pkg::cmd_t     cmd,
	output logic               pop,
	output rsrs_pkg::div_req_t div_req,
	input  rsrs_pkg::div_rsp_t div_rsp,
	output logic               result_valid,
	input  logic               result_stall,
	output rsrs_pkg::result_t  result
);

	localparam int OW  = rsrs_pkg::OFF_W;
	localparam int LW  = rsrs_pkg::LEN_W;
	localparam int WTW = rsrs_pkg::WITHIN_W;
	localparam int SW  = rsrs_pkg::STRIPE_W;
	localparam int WW  = rsrs_pkg::WID_W;
	localparam int QW  = rsrs_pkg::QUO_W;
	localparam int KS  = rsrs_pkg::KIB_SHIFT;
	localparam int CNT_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

	rsrs_pkg::walk_state_t state_q, state_d;

	logic [OW-1:0]    obj_q;
	logic [WTW-1:0]   within_q;
	logic [WW-1:0]    tgt_q;
	logic [LW-1:0]    remain_q;
	logic [LW-1:0]    done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KS-1:0]    lo_q;
	logic             res_valid_q;
	rsrs_pkg::result_t res_q;

	logic          load_ok;
	logic          load_unsup;
	logic          start_split;
	logic          emit;
	logic [SW-1:0] stripe;
	logic [SW-1:0] room;
	logic          fits_all;
	logic [LW-1:0] piece;
	logic [LW-1:0] remain_d;
	logic [LW-1:0] done_d;
	logic          last;
	logic [WW:0]   tgt_inc;

	assign load_ok = !res_valid_q || !result_stall;
	assign stripe  = {cfg.stripe_kib, {KS{1'b0}}};

	// Next piece from the cursor
	always_comb begin
		room     = stripe - {1'b0, within_q};
		fits_all = ({{(SW-LW){1'b0}}, remain_q} < room);
		piece    = fits_all ? remain_q : room[LW-1:0];
		remain_d = remain_q - piece;
		done_d   = done_q + piece;
		last     = (remain_d == '0) || (cnt_q == CNT_W'(MAX_PIECES - 1));
		tgt_inc  = {1'b0, tgt_q} + (WW+1)'(1);
	end

	// Next state and handshakes
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load_unsup  = 1'b0;
		start_split = 1'b0;
		emit        = 1'b0;
		case (state_q)
			rsrs_pkg::WALK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == rsrs_pkg::CMD_UNSUP) begin
						if (load_ok) begin
							pop        = 1'b1;
							load_unsup = 1'b1;
						end
					end else begin
						pop         = 1'b1;
						start_split = 1'b1;
						state_d     = rsrs_pkg::WALK_DIV;
					end
				end
			end
			rsrs_pkg::WALK_DIV: begin
				if (div_rsp.done) begin
					state_d = rsrs_pkg::WALK_EMIT;
				end
			end
			rsrs_pkg::WALK_EMIT: begin
				if (load_ok) begin
					emit = 1'b1;
					if (last) begin
						state_d = rsrs_pkg::WALK_IDLE;
					end
				end
			end
			default: begin
				state_d = rsrs_pkg::WALK_IDLE;
			end
		endcase
	end

	always_comb begin
		div_req.start    = start_split;
		div_req.dividend = cmd.offset[OW-1:KS];
		div_req.divisor  = cfg.stripe_kib;
		div_req.modulus  = cfg.width;
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsrs_pkg::WALK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_unsup || emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Cursor and result payload
	always_ff @(posedge clk) begin
		if (start_split) begin
			lo_q     <= cmd.offset[KS-1:0];
			remain_q <= cmd.length;
			done_q   <= '0;
			cnt_q    <= '0;
		end
		if (state_q == rsrs_pkg::WALK_DIV && div_rsp.done) begin
			obj_q    <= {{(OW-QW){1'b0}}, div_rsp.quotient};
			within_q <= {div_rsp.remainder, lo_q};
			tgt_q    <= div_rsp.residue;
		end
		if (emit) begin
			remain_q <= remain_d;
			done_q   <= done_d;
			cnt_q    <= cnt_q + CNT_W'(1);
			if (fits_all) begin
				within_q <= within_q + {{(WTW-LW){1'b0}}, piece};
			end else begin
				within_q <= '0;
				obj_q    <= obj_q + OW'(1);
				tgt_q    <= (tgt_inc == {1'b0, cfg.width}) ? '0 : tgt_inc[WW-1:0];
			end
			res_q.object_id     <= obj_q;
			res_q.object_byte   <= within_q;
			res_q.piece_length  <= piece;
			res_q.target_index  <= tgt_q;
			res_q.bytes_done    <= done_d;
			res_q.unsupported   <= 1'b0;
			res_q.last_piece    <= last;
		end else if (load_unsup) begin
			res_q.object_id     <= '0;
			res_q.object_byte   <= '0;
			res_q.piece_length  <= '0;
			res_q.target_index  <= '0;
			res_q.bytes_done    <= '0;
			res_q.unsupported   <= 1'b1;
			res_q.last_piece    <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: rtl/raid0_stripe_request_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid0_stripe_request_splitter
// Splits byte requests into stripe-sized pieces under RAID0 striping.
// ----------------------------------------------------------------------------
// Each request goes through setup in the back end (queue pop, a bit-serial
// divide of the offset by the stripe size, which also yields the target
// index, and the cursor load), then gives one piece per cycle while the
// result side is not stalled. A two-entry queue lets the input side take
// up to two more requests while one is being split. Zero-length requests
// are taken and give no result; under a non-RAID0 policy a request gives
// one result flagged unsupported.
// Configuration writes take effect at once and belong in idle periods only.
// ----------------------------------------------------------------------------
module raid0_stripe_request_splitter #(
	parameter int OFFSET_BITS = 48,
	parameter int MAX_PIECES  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                request_valid,
	output logic                                request_stall,
	input  rsrs_pkg::request_t                  request,
	output logic                                result_valid,
	input  logic                                result_stall,
	output rsrs_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [rsrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int KW = rsrs_pkg::KIB_W;
	localparam int WW = rsrs_pkg::WID_W;

	logic [KW-1:0] stripe_size_kib_q;
	logic [WW-1:0] stripe_width_q;
	logic          policy_is_raid0_q;

	rsrs_pkg::cfg_t     cfg;
	rsrs_pkg::cmd_t     push_cmd;
	rsrs_pkg::cmd_t     head;
	rsrs_pkg::div_req_t div_req;
	rsrs_pkg::div_rsp_t div_rsp;
	logic               push;
	logic               pop;
	logic               full;
	logic               nonempty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_size_kib_q <= rsrs_pkg::RST_KIB;
			stripe_width_q    <= rsrs_pkg::RST_WIDTH;
			policy_is_raid0_q <= rsrs_pkg::RST_RAID0;
		end else if (cfg_we) begin
			case (cfg_index)
				rsrs_pkg::CFG_STRIPE_SIZE_KIB: stripe_size_kib_q <= cfg_data;
				rsrs_pkg::CFG_STRIPE_WIDTH:    stripe_width_q    <= cfg_data[WW-1:0];
				rsrs_pkg::CFG_POLICY_IS_RAID0: policy_is_raid0_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Normalize stripe size and width
	always_comb begin
		if (stripe_size_kib_q == '0) begin
			cfg.stripe_kib = KW'(1);
		end else if (stripe_size_kib_q > rsrs_pkg::MAX_KIB) begin
			cfg.stripe_kib = rsrs_pkg::MAX_KIB;
		end else begin
			cfg.stripe_kib = stripe_size_kib_q;
		end
		cfg.width = (stripe_width_q == '0) ? WW'(1) : stripe_width_q;
		cfg.raid0 = policy_is_raid0_q;
	end

	rsrs_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.cfg           (cfg),
		.queue_full    (full),
		.push          (push),
		.cmd           (push_cmd)
	);

	rsrs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	rsrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsrs_walk #(
		.MAX_PIECES (MAX_PIECES)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_valid    (nonempty),
		.cmd          (head),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: rtl/rsrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrs_checker
// Port-level checks on the result side of the stripe request splitter.
// ----------------------------------------------------------------------------
`include "raid0_stripe_request_splitter_assert.svh"

module rsrs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input rsrs_pkg::result_t result
);

	// Unsupported requests end at once and carry no bytes
	`RSRS_ASSERT_IMP(a_unsup_final, result_valid && result.unsupported, result.last_piece && (result.piece_length == '0) && (result.bytes_done == '0), "unsupported result not a bare final result")

	// Every real piece carries bytes
	`RSRS_ASSERT_IMP(a_piece_nonzero, result_valid && !result.unsupported, result.piece_length != '0, "empty piece")

	// Running count covers at least this piece
	`RSRS_ASSERT_IMP(a_done_covers, result_valid, result.bytes_done >= result.piece_length, "bytes done below piece length")

	// A stalled result holds
	`RSRS_ASSERT_NXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind raid0_stripe_request_splitter rsrs_checker u_rsrs_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RAID0 stripe request splitter. Byte requests go
// in through the valid/stall port and every piece that comes out is compared
// field by field with a piece list worked out in the bench from the current
// stripe size, width and policy. A directed set hits the corner cases first.
// Randomized phases under changing register settings follow, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int OFF_W = rsrs_pkg::OFF_W;
	localparam int LEN_W = rsrs_pkg::LEN_W;
	localparam int KIB_W = rsrs_pkg::KIB_W;
	localparam int WID_W = rsrs_pkg::WID_W;
	localparam int WITHIN_W = rsrs_pkg::WITHIN_W;
	localparam int CFG_IDX_W = rsrs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = rsrs_pkg::CFG_DATA_W;
	localparam int KIB_SHIFT = rsrs_pkg::KIB_SHIFT;
	localparam int PIECE_LIMIT = 64;
	localparam logic [OFF_W-1:0] OFF_TOP = {OFF_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_REQUESTS = 38;

	// Expected pieces of every accepted request, oldest first
	class piece_scoreboard;
		rsrs_pkg::result_t pending_pieces[$];
		logic [KIB_W-1:0] stripe_kib;
		logic [WID_W-1:0] stripe_width;
		logic raid0;
		int mismatches;

		function new();
			stripe_kib = rsrs_pkg::RST_KIB;
			stripe_width = rsrs_pkg::RST_WIDTH;
			raid0 = rsrs_pkg::RST_RAID0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			rsrs_pkg::CFG_STRIPE_SIZE_KIB: stripe_kib = data;
			rsrs_pkg::CFG_STRIPE_WIDTH: stripe_width = data[WID_W-1:0];
			rsrs_pkg::CFG_POLICY_IS_RAID0: raid0 = data[0];
			default: ;
			endcase
		endfunction

		// Stripe in bytes after clamping the KiB register to 1..MAX_KIB
		function bit [63:0] stripe_bytes();
			bit [63:0] kib;
			kib = 64'(stripe_kib);
			if (kib == 0)
				kib = 1;
			if (kib > 64'(rsrs_pkg::MAX_KIB))
				kib = 64'(rsrs_pkg::MAX_KIB);
			return kib << KIB_SHIFT;
		endfunction

		function string piece_text(rsrs_pkg::result_t r);
			return $sformatf("obj=%h off=%h len=%h tgt=%h done=%h unsup=%b last=%b",
				r.object_id, r.object_byte, r.piece_length, r.target_index,
				r.bytes_done, r.unsupported, r.last_piece);
		endfunction

		// Split one accepted request into the pieces it must produce
		function void split_request(rsrs_pkg::request_t req);
			bit [63:0] off, len, stripe, wid, avail, obj, pos, tgt;
			bit [63:0] left, done, room, size;
			int n;
			rsrs_pkg::result_t piece;
			off = 64'(req.request_offset);
			len = 64'(req.request_length);
			piece = '0;
			if (len == 0)
				return;
			if (!raid0) begin
				piece.unsupported = 1'b1;
				piece.last_piece = 1'b1;
				pending_pieces.push_back(piece);
				return;
			end
			stripe = stripe_bytes();
			wid = (stripe_width == 0) ? 64'd1 : 64'(stripe_width);
			if (len > 64'(rsrs_pkg::MAX_REQ_LEN))
				len = 64'(rsrs_pkg::MAX_REQ_LEN);
			// cut short at the top of the address space
			avail = 64'(OFF_TOP) - off;
			if (len - 1 > avail)
				len = avail + 1;
			obj = off / stripe;
			pos = off % stripe;
			tgt = obj % wid;
			left = len;
			done = 0;
			n = 0;
			while (left != 0 && n < PIECE_LIMIT) begin
				room = stripe - pos;
				size = (left < room) ? left : room;
				done += size;
				left -= size;
				piece.object_id = obj[OFF_W-1:0];
				piece.object_byte = pos[WITHIN_W-1:0];
				piece.piece_length = size[LEN_W-1:0];
				piece.target_index = tgt[WID_W-1:0];
				piece.bytes_done = done[LEN_W-1:0];
				piece.unsupported = 1'b0;
				piece.last_piece = (left == 0 || n + 1 == PIECE_LIMIT);
				pending_pieces.push_back(piece);
				n++;
				pos += size;
				if (pos == stripe) begin
					pos = 0;
					obj += 1;
					tgt = (tgt + 1 == wid) ? 64'd0 : tgt + 1;
				end
			end
		endfunction

		function void check_piece(rsrs_pkg::result_t got);
			rsrs_pkg::result_t want;
			if (pending_pieces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: piece with no request pending: %s", $time, piece_text(got));
				return;
			end
			want = pending_pieces.pop_front();
			if (got.object_id !== want.object_id ||
				got.object_byte !== want.object_byte ||
				got.piece_length !== want.piece_length ||
				got.target_index !== want.target_index ||
				got.bytes_done !== want.bytes_done ||
				got.unsupported !== want.unsupported ||
				got.last_piece !== want.last_piece) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: piece mismatch", $time);
					$display("  expected %s", piece_text(want));
					$display("  actual   %s", piece_text(got));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic request_valid;
	logic request_stall;
	rsrs_pkg::request_t request;
	logic result_valid;
	logic result_stall = 1'b0;
	rsrs_pkg::result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	piece_scoreboard ledger;
	bit steady_sender;
	int idle_cycles = 0;
	int stall_run = 0;
	logic stall_now = 1'b0;

	raid0_stripe_request_splitter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request(request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side in random runs: open stretches, short and long stalls
	always @(posedge clk) begin
		if (stall_run == 0) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				stall_now = 1'b0;
				stall_run = int'($urandom_range(20, 120));
			end
			2: begin
				stall_now = 1'b1;
				stall_run = int'($urandom_range(15, 60));
			end
			3, 4, 5: begin
				stall_now = 1'b1;
				stall_run = int'($urandom_range(1, 3));
			end
			default: begin
				stall_now = 1'b0;
				stall_run = int'($urandom_range(1, 4));
			end
			endcase
		end else begin
			stall_run--;
		end
		result_stall <= stall_now;
	end

	// Check every piece taken on the result side
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			ledger.check_piece(result);
	end

	// End the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_valid && !request_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic rsrs_pkg::request_t make_request(logic [OFF_W-1:0] off,
		logic [LEN_W-1:0] len);
		rsrs_pkg::request_t r;
		r.request_offset = off;
		r.request_length = len;
		return r;
	endfunction

	function automatic int sender_gap();
		if (steady_sender)
			return 0;
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return 0;
		9: return int'($urandom_range(10, 60));
		default: return int'($urandom_range(1, 3));
		endcase
	endfunction

	// Offsets aimed at stripe boundaries and the top; lengths mostly multi-piece
	function automatic rsrs_pkg::request_t random_request();
		bit [63:0] wide, stripe;
		rsrs_pkg::request_t r;
		wide = {$urandom(), $urandom()};
		stripe = ledger.stripe_bytes();
		case ($urandom_range(0, 7))
		0, 1: r.request_offset = wide[OFF_W-1:0];
		2: r.request_offset = OFF_TOP - OFF_W'($urandom_range(0, 70000));
		3, 4, 5: r.request_offset = OFF_W'((wide[OFF_W-1:0] / stripe) * stripe)
			- OFF_W'($urandom_range(0, 1500));
		default: r.request_offset = OFF_W'($urandom_range(0, 1 << 20));
		endcase
		case ($urandom_range(0, 15))
		0: r.request_length = '0;
		1, 2: r.request_length = LEN_W'($urandom_range(rsrs_pkg::MAX_REQ_LEN, 16'hFFFF));
		3, 4, 5, 6: r.request_length = LEN_W'($urandom());
		default: r.request_length = LEN_W'($urandom_range(1, 20000));
		endcase
		return r;
	endfunction

	// Present one request after a random gap and hold it until taken
	task automatic send_request(input rsrs_pkg::request_t req);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			request_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= req;
		@(posedge clk);
		while (request_stall)
			@(posedge clk);
		ledger.split_request(req);
	endtask

	// Drop valid, wait for all pieces, then let zero-length requests drain
	task automatic settle();
		request_valid <= 1'b0;
		while (ledger.pending_pieces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		ledger.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram all registers once the block is idle; upper bits of the width and policy writes carry noise
	task automatic configure(input logic [KIB_W-1:0] kib, input logic [WID_W-1:0] wid,
		input logic pol);
		logic [CFG_DATA_W-1:0] noise;
		settle();
		noise = CFG_DATA_W'($urandom());
		write_reg(rsrs_pkg::CFG_STRIPE_SIZE_KIB, kib);
		write_reg(rsrs_pkg::CFG_STRIPE_WIDTH, {noise[CFG_DATA_W-1:WID_W], wid});
		write_reg(rsrs_pkg::CFG_POLICY_IS_RAID0, {noise[CFG_DATA_W-1:1], pol});
		write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
	endtask

	initial begin
		logic [KIB_W-1:0] phase_kib;
		logic [WID_W-1:0] phase_width;
		logic phase_raid0;
		ledger = new();
		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady_sender = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 128 KiB stripes, one target
		send_request(make_request(48'd0, 16'd1));
		send_request(make_request(48'd0, rsrs_pkg::MAX_REQ_LEN));
		send_request(make_request(48'd131071, 16'd2));
		send_request(make_request(48'd0, 16'd0));
		send_request(make_request(OFF_TOP, 16'd1));
		send_request(make_request(OFF_TOP - 48'd99, rsrs_pkg::MAX_REQ_LEN));
		send_request(make_request(OFF_TOP, 16'hFFFF));
		send_request(make_request(48'd1, 16'hFFFF));

		// Smallest stripe: full-length requests split into 63 and 64 pieces
		configure(21'd1, 8'd3, 1'b1);
		send_request(make_request(48'd0, rsrs_pkg::MAX_REQ_LEN));
		send_request(make_request(48'd1, rsrs_pkg::MAX_REQ_LEN));
		send_request(make_request(48'd1023, 16'd2));
		send_request(make_request(OFF_TOP - 48'd5000, rsrs_pkg::MAX_REQ_LEN));
		send_request(make_request(48'h5555_5555_5555, 16'hAAAA));

		// Zero stripe size and zero width fall back to one
		configure(21'd0, 8'd0, 1'b1);
		send_request(make_request(48'd2047, 16'd3000));
		send_request(make_request(48'hAAAA_AAAA_AAAA, 16'h5555));

		// Oversized stripe clamps to 1 GiB; widest target set
		configure(21'h1F_FFFF, 8'd255, 1'b1);
		send_request(make_request(48'd300 * 48'h4000_0000 - 48'd5, 16'd10));
		send_request(make_request(OFF_TOP, 16'd1));
		send_request(make_request(OFF_TOP - 48'd3, 16'd8));

		// Unsupported policy: one flagged result, none for zero length
		configure(21'd4, 8'd2, 1'b0);
		send_request(make_request(48'd0, 16'd0));
		send_request(make_request(48'd123, 16'd1));
		send_request(make_request(OFF_TOP, 16'hFFFF));

		// Random phases under changing settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: begin
				phase_kib = 21'd0;
				phase_width = 8'd0;
			end
			1: begin
				phase_kib = rsrs_pkg::MAX_KIB;
				phase_width = 8'd255;
			end
			2: begin
				phase_kib = 21'h1F_FFFF;
				phase_width = 8'd254;
			end
			3: begin
				phase_kib = 21'd1;
				phase_width = 8'd255;
			end
			default: begin
				case ($urandom_range(0, 5))
				0, 1, 2: phase_kib = KIB_W'($urandom_range(1, 4));
				3: phase_kib = KIB_W'($urandom_range(5, 64));
				4: phase_kib = KIB_W'($urandom());
				default: phase_kib = rsrs_pkg::RST_KIB;
				endcase
				case ($urandom_range(0, 3))
				0: phase_width = WID_W'($urandom_range(1, 255));
				1: phase_width = WID_W'($urandom_range(2, 8));
				2: phase_width = 8'd1;
				default: phase_width = 8'd255;
				endcase
			end
			endcase
			phase_raid0 = (p > 3 && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
			configure(phase_kib, phase_width, phase_raid0);
			steady_sender = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_REQUESTS; i++)
				send_request(random_request());
		end

		settle();
		if (ledger.mismatches == 0 && ledger.pending_pieces.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
